// File: sv/timed_state_debouncer_assert.svh
// Assertion macros used by the debouncer checker (tsd_checker).
`ifndef TIMED_STATE_DEBOUNCER_ASSERT_SVH
`define TIMED_STATE_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tsd_pkg.sv
`timescale 1ns / 1ps

package tsd_pkg;

  // Configuration register map (byte addresses).
  localparam int unsigned PADDR_W = 4;
  localparam logic [PADDR_W-1:0] ADDR_MISSING_GRACE = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_ENTER_DURATION = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_EXIT_DURATION = 4'h8;

  localparam logic [31:0] MISSING_GRACE_RESET = 32'd200000;
  localparam logic [31:0] ENTER_DURATION_RESET = 32'd100000;
  localparam logic [31:0] EXIT_DURATION_RESET = 32'd150000;

  // Q16.16 value of 1.0.
  localparam logic [16:0] UNIT_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_CANDIDATE = 2'd1,
    PH_ACTIVE = 2'd2
  } tsd_phase_t;

  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_BEGAN = 2'd1,
    TR_ENDED = 2'd2,
    TR_CANCELLED = 2'd3
  } tsd_trans_t;

  typedef enum logic [1:0] {
    FL_NONE = 2'd0,
    FL_STALE = 2'd1,
    FL_EXIT_PENDING = 2'd2
  } tsd_flag_t;

  // Observation class decided by the front end.
  typedef enum logic [1:0] {
    OP_MISSING = 2'd0,
    OP_HOLD = 2'd1,
    OP_RELEASE = 2'd2
  } tsd_op_t;

  typedef struct packed {
    logic [31:0] state_tag;
    logic input_valid;
    logic condition_met;
    logic signed [31:0] confidence_in;
    logic signed [31:0] quality_in;
    logic [63:0] frame_number;
    logic [63:0] time_us;
  } tsd_obs_t;

  typedef struct packed {
    logic [31:0] state_tag_out;
    logic [1:0] phase;
    logic [1:0] transition;
    logic [1:0] status_flag;
    logic [16:0] confidence_out;
    logic [16:0] quality_out;
    logic [63:0] began_frame;
    logic [63:0] frame_out;
    logic [63:0] time_out;
  } tsd_res_t;

  // Classified word held in the queue.
  typedef struct packed {
    tsd_op_t op;
    logic [31:0] state_tag;
    logic [16:0] confidence;
    logic [16:0] quality;
    logic [63:0] frame_number;
    logic [63:0] time_us;
  } tsd_entry_t;

  typedef struct packed {
    logic [31:0] missing_grace_us;
    logic [31:0] enter_duration_us;
    logic [31:0] exit_duration_us;
  } tsd_cfg_t;

  // Clamp signed Q16.16 to 0..1.
  function automatic logic [16:0] clamp_unit(input logic signed [31:0] raw);
    logic [16:0] res;
    if (raw[31]) begin
      res = '0;
    end else if (raw > $signed({15'd0, UNIT_Q16})) begin
      res = UNIT_Q16;
    end else begin
      res = raw[16:0];
    end
    return res;
  endfunction

endpackage

// File: sv/tsd_front.sv
`timescale 1ns / 1ps

module tsd_front import tsd_pkg::*; (
  input  tsd_obs_t   obs,
  output tsd_entry_t entry
);

  tsd_op_t op;

  // Classify: missing, condition held, condition released.
  always_comb begin
    priority if (!obs.input_valid) begin
      op = OP_MISSING;
    end else if (obs.condition_met) begin
      op = OP_HOLD;
    end else begin
      op = OP_RELEASE;
    end
  end

  always_comb begin
    entry.op = op;
    entry.state_tag = obs.state_tag;
    entry.confidence = clamp_unit(obs.confidence_in);
    entry.quality = clamp_unit(obs.quality_in);
    entry.frame_number = obs.frame_number;
    entry.time_us = obs.time_us;
  end

endmodule

// File: sv/tsd_queue.sv
`timescale 1ns / 1ps

module tsd_queue import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tsd_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output tsd_entry_t head
);

  tsd_entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/tsd_back.sv
`timescale 1ns / 1ps

module tsd_back import tsd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  tsd_cfg_t   cfg,
  input  logic       head_valid,
  input  tsd_entry_t head,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output tsd_res_t   res
);

  tsd_phase_t phase, phase_next;
  logic [TIME_WIDTH-1:0] cand_start, cand_start_next;
  logic [TIME_WIDTH-1:0] exit_start, exit_start_next;
  logic [TIME_WIDTH-1:0] miss_start, miss_start_next;
  logic [63:0] began, began_next;

  tsd_trans_t trans;
  tsd_flag_t flag;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] miss_eff, cand_eff, exit_eff;
  logic miss_done, enter_done, exit_done;

  function automatic logic time_passed(
    input logic [TIME_WIDTH-1:0] t_now,
    input logic [TIME_WIDTH-1:0] t_start,
    input logic [31:0] span
  );
    logic [TIME_WIDTH-1:0] diff;
    diff = t_now - t_start;
    return (t_now >= t_start) && (diff >= TIME_WIDTH'(span));
  endfunction

  assign now = head.time_us[TIME_WIDTH-1:0];

  // A stored miss or exit start of zero means unset (candidate: phase inactive); the interval then starts at this word.
  assign miss_eff = (miss_start == '0) ? now : miss_start;
  assign cand_eff = (phase == PH_INACTIVE) ? now : cand_start;
  assign exit_eff = (exit_start == '0) ? now : exit_start;

  assign miss_done = time_passed(now, miss_eff, cfg.missing_grace_us);
  assign enter_done = time_passed(now, cand_eff, cfg.enter_duration_us);
  assign exit_done = time_passed(now, exit_eff, cfg.exit_duration_us);

  always_comb begin
    phase_next = phase;
    cand_start_next = cand_start;
    exit_start_next = exit_start;
    miss_start_next = miss_start;
    began_next = began;
    trans = TR_NONE;
    flag = FL_NONE;
    unique case (head.op)
      OP_MISSING: begin
        if (phase != PH_INACTIVE) begin
          if (!miss_done) begin
            miss_start_next = miss_eff;
            flag = FL_STALE;
          end else begin
            phase_next = PH_INACTIVE;
            cand_start_next = '0;
            exit_start_next = '0;
            miss_start_next = '0;
            began_next = '0;
            trans = TR_CANCELLED;
          end
        end
      end
      OP_HOLD: begin
        miss_start_next = '0;
        exit_start_next = '0;
        cand_start_next = cand_eff;
        if (phase == PH_ACTIVE) begin
          phase_next = PH_ACTIVE;
        end else if (enter_done) begin
          phase_next = PH_ACTIVE;
          began_next = head.frame_number;
          trans = TR_BEGAN;
        end else begin
          phase_next = PH_CANDIDATE;
        end
      end
      OP_RELEASE: begin
        miss_start_next = '0;
        if (phase == PH_CANDIDATE) begin
          phase_next = PH_INACTIVE;
          cand_start_next = '0;
        end else if (phase == PH_ACTIVE) begin
          if (exit_done) begin
            phase_next = PH_INACTIVE;
            cand_start_next = '0;
            exit_start_next = '0;
            began_next = '0;
            trans = TR_ENDED;
          end else begin
            exit_start_next = exit_eff;
            flag = FL_EXIT_PENDING;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Advance when the output register is free or being drained.
  assign pop = head_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_INACTIVE;
      cand_start <= '0;
      exit_start <= '0;
      miss_start <= '0;
      began <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        cand_start <= cand_start_next;
        exit_start <= exit_start_next;
        miss_start <= miss_start_next;
        began <= began_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.state_tag_out <= head.state_tag;
      res.phase <= phase_next;
      res.transition <= trans;
      res.status_flag <= flag;
      res.confidence_out <= head.confidence;
      res.quality_out <= head.quality;
      res.began_frame <= began_next;
      res.frame_out <= head.frame_number;
      res.time_out <= head.time_us;
    end
  end

endmodule

// File: sv/timed_state_debouncer.sv
`timescale 1ns / 1ps

// Timed three-phase debouncer (inactive, candidate, active) over one
// timestamped observation word per frame. A present observation with the
// condition true makes the state a candidate; it goes active once the
// condition has held for enter_duration_us and ends once the condition has
// been absent for exit_duration_us. A missing observation is tolerated for
// missing_grace_us, after which the state is cancelled and cleared. Miss and
// exit start times of zero mean unset, and a timestamp that goes backwards
// never counts as elapsed; times are compared on their low TIME_WIDTH bits.
// Confidence and quality come in as signed Q16.16 and leave clamped to 0..1.
// Each obs word yields exactly one res word. Throughput is one word per
// clock while res_ready stays high; an accepted word is written into a
// two-entry classification queue, then goes through the state update into
// the res output register, which holds while res_ready is low. The loop on
// the phase and start-time registers sets that rate. The queue lets obs
// keep flowing while res is stalled, until both entries are full. The
// three timing registers sit at byte addresses 0x0, 0x4 and 0x8 of the APB
// port and are to be written only while the block is idle.
module timed_state_debouncer import tsd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               obs_valid,
  output logic               obs_ready,
  input  tsd_obs_t           obs,
  output logic               res_valid,
  input  logic               res_ready,
  output tsd_res_t           res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tsd_cfg_t cfg;
  tsd_entry_t entry;
  tsd_entry_t head;
  logic q_full;
  logic head_valid;
  logic pop;
  logic cfg_write;

  // Configuration registers: write on the APB access phase.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.missing_grace_us <= MISSING_GRACE_RESET;
      cfg.enter_duration_us <= ENTER_DURATION_RESET;
      cfg.exit_duration_us <= EXIT_DURATION_RESET;
    end else if (cfg_write) begin
      unique case (paddr)
        ADDR_MISSING_GRACE: cfg.missing_grace_us <= pwdata;
        ADDR_ENTER_DURATION: cfg.enter_duration_us <= pwdata;
        ADDR_EXIT_DURATION: cfg.exit_duration_us <= pwdata;
        default: cfg <= cfg;
      endcase
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    unique case (paddr)
      ADDR_MISSING_GRACE: prdata = cfg.missing_grace_us;
      ADDR_ENTER_DURATION: prdata = cfg.enter_duration_us;
      ADDR_EXIT_DURATION: prdata = cfg.exit_duration_us;
      default: prdata = '0;
    endcase
  end

  // Front end: clamp and classify the incoming word.
  tsd_front u_front (
    .obs   (obs),
    .entry (entry)
  );

  // Take a new word whenever the queue has a free slot.
  assign obs_ready = !q_full;

  tsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (obs_valid && obs_ready),
    .push_data  (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: phase update and output register.
  tsd_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

// File: sv/tsd_checker.sv
`timescale 1ns / 1ps
`include "timed_state_debouncer_assert.svh"

module tsd_checker import tsd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     res_valid,
  input logic     res_ready,
  input tsd_res_t res
);

  // A stalled result word holds.
  `TSD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "res changed while stalled")

  // Only an active state carries a start frame.
  `TSD_ASSERT_NOW(a_began_zero, res_valid && res.phase != PH_ACTIVE, res.began_frame == 64'd0, "began_frame set while not active")

  // A begin lands in active and records this frame.
  `TSD_ASSERT_NOW(a_began, res_valid && res.transition == TR_BEGAN, res.phase == PH_ACTIVE && res.began_frame == res.frame_out, "began without active phase")

  // End and cancel both drop to inactive.
  `TSD_ASSERT_NOW(a_drop, res_valid && (res.transition == TR_ENDED || res.transition == TR_CANCELLED), res.phase == PH_INACTIVE, "end or cancel left state set")

endmodule

bind timed_state_debouncer tsd_checker u_tsd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// File: bench/debounce_checker.sv
`timescale 1ns / 1ps

module debounce_checker import tsd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               obs_valid,
  input  logic               obs_ready,
  input  tsd_obs_t           obs,
  input  logic               res_valid,
  input  logic               res_ready,
  input  tsd_res_t           res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TIME_WIDTH);

  logic [31:0] grace_us;
  logic [31:0] enter_us;
  logic [31:0] exit_us;

  tsd_phase_t  phase_now;
  logic [63:0] cand_t;
  logic [63:0] exit_t;
  logic [63:0] miss_t;
  logic [63:0] began_at;

  tsd_res_t debounced_q[$];

  initial fail_count = 0;

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch on %s: got %h want %h", $time, field, got, want);
    fail_count++;
  endtask

  function automatic logic [16:0] unit_clamp(input logic [31:0] raw);
    if (raw[31]) return '0;
    if (raw > 32'h0001_0000) return UNIT_Q16;
    return raw[16:0];
  endfunction

  // a clock that ran backwards never counts as elapsed
  function automatic bit span_over(input logic [63:0] now, input logic [63:0] start,
                                   input logic [31:0] span);
    return (now >= start) && ((now - start) >= {32'd0, span});
  endfunction

  task automatic drop_history();
    phase_now = PH_INACTIVE;
    cand_t = '0;
    exit_t = '0;
    miss_t = '0;
    began_at = '0;
  endtask

  task automatic debounce_step(input tsd_obs_t o, output tsd_res_t r);
    logic [63:0] now;
    tsd_trans_t  trans;
    tsd_flag_t   flag;
    now = o.time_us & TIME_MASK;
    trans = TR_NONE;
    flag = FL_NONE;
    if (!o.input_valid) begin
      if (phase_now != PH_INACTIVE) begin
        if (miss_t == '0) miss_t = now;
        if (!span_over(now, miss_t, grace_us)) begin
          flag = FL_STALE;
        end else begin
          drop_history();
          trans = TR_CANCELLED;
        end
      end
    end else begin
      miss_t = '0;
      if (o.condition_met) begin
        exit_t = '0;
        if (phase_now == PH_INACTIVE) begin
          phase_now = PH_CANDIDATE;
          cand_t = now;
        end
        if (phase_now == PH_CANDIDATE && span_over(now, cand_t, enter_us)) begin
          phase_now = PH_ACTIVE;
          began_at = o.frame_number;
          trans = TR_BEGAN;
        end
      end else if (phase_now == PH_CANDIDATE) begin
        phase_now = PH_INACTIVE;
        cand_t = '0;
      end else if (phase_now == PH_ACTIVE) begin
        if (exit_t == '0) exit_t = now;
        if (span_over(now, exit_t, exit_us)) begin
          phase_now = PH_INACTIVE;
          cand_t = '0;
          exit_t = '0;
          began_at = '0;
          trans = TR_ENDED;
        end else begin
          flag = FL_EXIT_PENDING;
        end
      end
    end
    r.state_tag_out = o.state_tag;
    r.phase = phase_now;
    r.transition = trans;
    r.status_flag = flag;
    r.confidence_out = unit_clamp(o.confidence_in);
    r.quality_out = unit_clamp(o.quality_in);
    r.began_frame = began_at;
    r.frame_out = o.frame_number;
    r.time_out = o.time_us;
  endtask

  task automatic compare_word(input tsd_res_t got, input tsd_res_t want);
    if (got.state_tag_out !== want.state_tag_out)
      flag_mismatch("state_tag_out", got.state_tag_out, want.state_tag_out);
    if (got.phase !== want.phase)
      flag_mismatch("phase", got.phase, want.phase);
    if (got.transition !== want.transition)
      flag_mismatch("transition", got.transition, want.transition);
    if (got.status_flag !== want.status_flag)
      flag_mismatch("status_flag", got.status_flag, want.status_flag);
    if (got.confidence_out !== want.confidence_out)
      flag_mismatch("confidence_out", got.confidence_out, want.confidence_out);
    if (got.quality_out !== want.quality_out)
      flag_mismatch("quality_out", got.quality_out, want.quality_out);
    if (got.began_frame !== want.began_frame)
      flag_mismatch("began_frame", got.began_frame, want.began_frame);
    if (got.frame_out !== want.frame_out)
      flag_mismatch("frame_out", got.frame_out, want.frame_out);
    if (got.time_out !== want.time_out)
      flag_mismatch("time_out", got.time_out, want.time_out);
  endtask

  always @(posedge clk) begin : track
    tsd_res_t want;
    if (rst) begin
      grace_us = MISSING_GRACE_RESET;
      enter_us = ENTER_DURATION_RESET;
      exit_us = EXIT_DURATION_RESET;
      drop_history();
      debounced_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_MISSING_GRACE:  grace_us = pwdata;
          ADDR_ENTER_DURATION: enter_us = pwdata;
          ADDR_EXIT_DURATION:  exit_us = pwdata;
          default: ;
        endcase
      end
      if (obs_valid && obs_ready) begin
        debounce_step(obs, want);
        debounced_q.push_back(want);
      end
      if (res_valid && res_ready) begin
        if (debounced_q.size() == 0) flag_mismatch("unexpected word", res.frame_out, '0);
        else compare_word(res, debounced_q.pop_front());
      end
    end
    pending <= debounced_q.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsd_pkg::*;

  localparam int unsigned TIME_WIDTH = 64;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned WORDS_PER_PHASE = 65;

  // shape of one stretch of random observations
  typedef enum {RUN_HOLD, RUN_RELEASE, RUN_MISSING, RUN_NOISE} run_kind_t;
  // how the three timing registers are chosen for a phase
  typedef enum {CFG_ZERO, CFG_MAX, CFG_TINY, CFG_MID, CFG_MIXED} cfg_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               obs_valid = 1'b0;
  logic               obs_ready;
  tsd_obs_t           obs = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  tsd_res_t           res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned fail_count;
  int unsigned pending;

  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned sink_hold = 0;
  int unsigned cycles = 0;
  int unsigned word_no = 0;
  logic [63:0] now_us = '0;

  timed_state_debouncer #(.TIME_WIDTH(TIME_WIDTH)) uut (
    .clk(clk), .rst(rst),
    .obs_valid(obs_valid), .obs_ready(obs_ready), .obs(obs),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Watch both channels and the register port; predict and compare there.
  debounce_checker #(.TIME_WIDTH(TIME_WIDTH)) watch (
    .clk(clk), .rst(rst),
    .obs_valid(obs_valid), .obs_ready(obs_ready), .obs(obs),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: drop ready for random stretches while idling is on.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      res_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(0, 14);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Present one word and hold it until taken. Valid stays high on return so
  // the next word can follow back to back; a gap drops it first.
  task automatic push_word(input tsd_obs_t w);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      obs_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    obs <= w;
    obs_valid <= 1'b1;
    do @(posedge clk); while (!obs_ready);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // that ends the access with pready high, and the bus then goes idle.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted word to come back, then let the
  // two-stage pipe run empty.
  task automatic settle(input int unsigned extra);
    obs_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Q16.16 corners: most negative, minus one lsb, zero, one lsb, just under one, one,
  // just over one, most positive.
  function automatic logic [31:0] q16_corner(input int unsigned k);
    case (k % 8)
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'h0000_FFFF;
      5: return 32'h0001_0000;
      6: return 32'h0001_0001;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Corners first, then a mix weighted toward the clamp boundaries.
  function automatic logic [31:0] q16_value(input int unsigned n);
    if (n < 16) return q16_corner(n);
    case ($urandom_range(0, 3))
      0: return q16_corner($urandom_range(0, 7));
      1: return $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] wide_value(input int unsigned n);
    if (n < 16) begin
      case (n % 4)
        0: return 64'h0;
        1: return {64{1'b1}};
        2: return 64'h8000_0000_0000_0001;
        default: ;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Build one observation around the given control bits and timestamp.
  task automatic offer(input bit valid, input bit cond, input logic [63:0] t);
    tsd_obs_t w;
    w.state_tag = 32'(wide_value(word_no + 1));
    w.input_valid = valid;
    w.condition_met = cond;
    w.confidence_in = q16_value(word_no);
    w.quality_in = q16_value(word_no + 3);
    w.frame_number = wide_value(word_no);
    w.time_us = t;
    word_no++;
    push_word(w);
  endtask

  function automatic logic [31:0] timing_value(input cfg_kind_t kind);
    case (kind)
      CFG_ZERO:  return 32'd0;
      CFG_MAX:   return 32'hFFFF_FFFF;
      CFG_TINY:  return $urandom_range(0, 400);
      CFG_MID:   return $urandom_range(1000, 200000);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'd0;
          1: return 32'hFFFF_FFFF;
          2: return $urandom_range(0, 400);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Advance the timeline, mostly forward in steps sized to the durations,
  // sometimes to zero, backward, past every duration, or anywhere at all.
  function automatic logic [63:0] next_time(input logic [63:0] t, input logic [31:0] scale);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return t - $urandom_range(0, scale);
    if (r < 12) return t + {32'd0, scale} + $urandom_range(0, 2);
    if (r < 14) return {$urandom, $urandom};
    return t + $urandom_range(0, scale / 3 + 1);
  endfunction

  initial begin
    cfg_kind_t   kind;
    run_kind_t   run;
    logic [31:0] grace;
    logic [31:0] enter;
    logic [31:0] leave;
    logic [31:0] scale;
    int unsigned words_left;
    int unsigned run_len;
    int unsigned r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset timing: grace 200000, enter 100000,
    // exit 150000.
    offer(1'b0, 1'b0, 64'd1000);       // missing while inactive
    offer(1'b0, 1'b1, 64'd2000);
    offer(1'b1, 1'b1, 64'd0);          // candidate starting at time zero
    offer(1'b1, 1'b1, 64'd99999);      // one short of the enter time
    offer(1'b1, 1'b1, 64'd100000);     // exactly the enter time: began
    offer(1'b1, 1'b1, 64'd120000);
    offer(1'b1, 1'b0, 64'd130000);     // exit pending
    offer(1'b1, 1'b0, 64'd279999);
    offer(1'b1, 1'b1, 64'd280000);     // condition back: exit timer cleared
    offer(1'b1, 1'b0, 64'd290000);
    offer(1'b1, 1'b0, 64'd440000);     // exactly the exit time: ended
    offer(1'b1, 1'b1, 64'd450000);
    offer(1'b1, 1'b0, 64'd460000);     // candidate drops without transition
    offer(1'b1, 1'b1, 64'd470000);
    offer(1'b0, 1'b1, 64'd480000);     // stale within grace
    offer(1'b0, 1'b0, 64'd679999);
    offer(1'b0, 1'b0, 64'd680000);     // grace used up: cancelled
    offer(1'b1, 1'b1, 64'd700000);
    offer(1'b1, 1'b1, 64'd650000);     // time went backwards
    offer(1'b1, 1'b1, 64'd800000);
    offer(1'b0, 1'b0, 64'd0);          // missing stamped at zero stays unset
    offer(1'b0, 1'b0, 64'd300000);     // so the grace restarts here
    offer(1'b0, 1'b1, 64'd400000);
    offer(1'b1, 1'b0, {64{1'b1}});     // exit timer at the top of the range
    offer(1'b1, 1'b0, 64'd1000);
    settle(4);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      // Hit both extremes first, then random settings.
      if (p == 0) kind = CFG_ZERO;
      else if (p == 1) kind = CFG_MAX;
      else kind = cfg_kind_t'($urandom_range(2, 4));

      // The last phase runs flat out; earlier ones idle most of the time.
      src_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);

      settle(4);
      grace = timing_value(kind);
      enter = timing_value(kind);
      leave = timing_value(kind);
      apb_write(ADDR_MISSING_GRACE, grace);
      apb_write(ADDR_ENTER_DURATION, enter);
      apb_write(ADDR_EXIT_DURATION, leave);

      scale = grace;
      if (enter > scale) scale = enter;
      if (leave > scale) scale = leave;

      // Mostly well-formed runs of hold, release or missing frames so the
      // timers actually expire; the rest is noise.
      words_left = WORDS_PER_PHASE;
      while (words_left != 0) begin
        r = $urandom_range(0, 99);
        if (r < 35) run = RUN_HOLD;
        else if (r < 65) run = RUN_RELEASE;
        else if (r < 85) run = RUN_MISSING;
        else run = RUN_NOISE;
        run_len = $urandom_range(1, 12);
        while (run_len != 0 && words_left != 0) begin
          now_us = next_time(now_us, scale);
          case (run)
            RUN_HOLD:    offer(1'b1, 1'b1, now_us);
            RUN_RELEASE: offer(1'b1, 1'b0, now_us);
            RUN_MISSING: offer(1'b0, 1'($urandom_range(0, 1)), now_us);
            default:     offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now_us);
          endcase
          run_len--;
          words_left--;
        end
      end
    end

    // Drain everything, let the pipe run empty, then judge.
    settle(8);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
